// ===== rtl/skrf_pkg.sv =====
// Shared types and constants for the scalar Kalman rate fuser.
`timescale 1ns / 1ps
package skrf_pkg;

  localparam int RATE_W   = 24;  // signed Q8.16
  localparam int VAR_W    = 32;  // unsigned Q16.16
  localparam int DEN_W    = VAR_W + 1;
  localparam int ACC_W    = 58;  // mv*est + var*gyro
  localparam int MUL_W    = VAR_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int EST_Q    = 24;  // quotient bits of the estimate division
  localparam int VAR_Q    = 32;  // quotient bits of the variance division
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [1:0] REG_PROCESS = 2'd0;
  localparam logic [1:0] REG_MEASURE = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;

  localparam logic [VAR_W-1:0] PROCESS_VAR_RST = 32'd262144;
  localparam logic [VAR_W-1:0] MEASURE_VAR_RST = 32'd32768;
  localparam logic [VAR_W-1:0] START_VAR_RST   = 32'd65536000;

  localparam logic OP_GYRO = 1'b0;
  localparam logic OP_ODOM = 1'b1;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;

  typedef struct packed {
    logic load_gyro;
    logic seed;
    logic predict;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic zero_var;
    logic dload_e;
    logic div_step;
    logic fin_e;
    logic dload_v;
    logic fin_v;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic d_zero;
  } status_t;

endpackage

// ===== rtl/skrf_cfg.sv =====
// APB configuration registers of the rate fuser.
`timescale 1ns / 1ps
module skrf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skrf_pkg::APB_AW-1:0]   paddr,
  input  logic [skrf_pkg::APB_DW-1:0]   pwdata,
  output logic [skrf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [skrf_pkg::VAR_W-1:0]    process_var,
  output logic [skrf_pkg::VAR_W-1:0]    measure_var
);
  import skrf_pkg::*;

  logic [VAR_W-1:0] start_var;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // start_var is read/write but unused; reset reloads the filter variance from its default
  always_ff @(posedge clk) begin
    if (rst) begin
      process_var <= PROCESS_VAR_RST;
      measure_var <= MEASURE_VAR_RST;
      start_var   <= START_VAR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROCESS: process_var <= pwdata;
        REG_MEASURE: measure_var <= pwdata;
        REG_START:   start_var   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROCESS: prdata = process_var;
      REG_MEASURE: prdata = measure_var;
      REG_START:   prdata = start_var;
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/skrf_dp.sv =====
// Datapath: filter state, shared multiplier, bit-serial divider, result register.
`timescale 1ns / 1ps
module skrf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  skrf_pkg::cmd_t                      cmd,
  output skrf_pkg::status_t                   status,
  input  logic signed [skrf_pkg::RATE_W-1:0]  rate_sample,
  input  logic [skrf_pkg::VAR_W-1:0]          process_var,
  input  logic [skrf_pkg::VAR_W-1:0]          measure_var,
  output logic signed [skrf_pkg::RATE_W-1:0]  rate_estimate,
  output logic [skrf_pkg::VAR_W-1:0]          estimate_variance
);
  import skrf_pkg::*;

  // filter state
  logic signed [RATE_W-1:0] est;
  logic [VAR_W-1:0]         var_q;
  logic signed [RATE_W-1:0] gyro;
  logic signed [RATE_W-1:0] prev;
  logic                     first;

  // working registers
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [DEN_W-1:0]         dd;
  logic [DEN_W-1:0]         rem;
  logic [VAR_Q-1:0]         low;
  logic [VAR_Q-1:0]         quo;
  logic                     neg;

  logic signed [RATE_W+1:0] est_sum;
  logic signed [RATE_W-1:0] est_pred;
  logic [VAR_W:0]           var_sum;
  logic [VAR_W-1:0]         var_pred;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]         acc_mag;
  logic [VAR_W*2-1:0]       vprod;
  logic [DEN_W:0]           trial;
  logic                     qbit;
  logic                     rnd_up;
  logic [VAR_Q:0]           qr;
  logic signed [RATE_W-1:0] est_div;
  logic [VAR_W-1:0]         var_div;

  assign status.first  = first;
  assign status.d_zero = (dd == '0);

  // prediction
  assign est_sum  = (RATE_W+2)'(est) + (RATE_W+2)'(gyro) - (RATE_W+2)'(prev);
  assign var_sum  = {1'b0, var_q} + {1'b0, process_var};
  assign var_pred = var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];

  always_comb begin
    if (est_sum > (RATE_W+2)'(RATE_MAX)) begin
      est_pred = RATE_MAX;
    end else if (est_sum < (RATE_W+2)'(RATE_MIN)) begin
      est_pred = RATE_MIN;
    end else begin
      est_pred = est_sum[RATE_W-1:0];
    end
  end

  // one shared multiplier, operands picked by the current step
  always_comb begin
    mul_a = $signed({1'b0, measure_var});
    mul_b = MUL_W'(est);
    if (cmd.mul_b) begin
      mul_a = $signed({1'b0, var_q});
      mul_b = MUL_W'(gyro);
    end else if (cmd.fin_e) begin
      mul_a = $signed({1'b0, var_q});
      mul_b = $signed({1'b0, measure_var});
    end
  end
  assign mul_p = mul_a * mul_b;

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign vprod   = prod[VAR_W*2-1:0];

  // restoring divider, one quotient bit per beat of the step command
  assign trial  = {rem, low[VAR_Q-1]} - {1'b0, dd};
  assign qbit   = ~trial[DEN_W];
  assign rnd_up = ({rem, 1'b0} >= {1'b0, dd});
  assign qr     = {1'b0, quo} + (VAR_Q+1)'(rnd_up);

  always_comb begin
    if (!neg) begin
      est_div = (qr > (VAR_Q+1)'(RATE_MAX)) ? RATE_MAX : $signed(qr[RATE_W-1:0]);
    end else begin
      est_div = (qr > (VAR_Q+1)'(1) << (RATE_W-1)) ? RATE_MIN
                : $signed(RATE_W'(0) - qr[RATE_W-1:0]);
    end
    var_div = qr[VAR_Q] ? '1 : qr[VAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est   <= '0;
      var_q <= START_VAR_RST;
      gyro  <= '0;
      prev  <= '0;
      first <= 1'b1;
    end else begin
      if (cmd.load_gyro) begin
        gyro <= rate_sample;
      end
      if (cmd.seed) begin
        first <= 1'b0;
        prev  <= rate_sample;
        est   <= rate_sample;
      end else if (cmd.predict) begin
        prev <= gyro;
        est  <= est_pred;
      end else if (cmd.fin_e) begin
        est <= est_div;
      end
      if (cmd.predict) begin
        var_q <= var_pred;
      end else if (cmd.zero_var) begin
        var_q <= '0;
      end else if (cmd.fin_v) begin
        var_q <= var_div;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a || cmd.mul_b || cmd.fin_e) begin
      prod <= mul_p;
    end
    if (cmd.mul_a) begin
      dd <= {1'b0, var_q} + {1'b0, measure_var};
    end
    if (cmd.mul_b) begin
      acc <= prod[ACC_W-1:0];
    end else if (cmd.sum) begin
      acc <= acc + $signed(prod[ACC_W-1:0]);
    end
    if (cmd.dload_e) begin
      // quotient stays below 2^EST_Q, so the top part starts below dd
      neg <= acc[ACC_W-1];
      rem <= DEN_W'(acc_mag >> EST_Q);
      low <= VAR_Q'(acc_mag << (VAR_Q - EST_Q));
      quo <= '0;
    end else if (cmd.dload_v) begin
      rem <= {1'b0, vprod[VAR_W*2-1:VAR_Q]};
      low <= vprod[VAR_Q-1:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? trial[DEN_W-1:0] : {rem[DEN_W-2:0], low[VAR_Q-1]};
      low <= {low[VAR_Q-2:0], 1'b0};
      quo <= {quo[VAR_Q-2:0], qbit};
    end
    if (cmd.emit) begin
      rate_estimate     <= est;
      estimate_variance <= var_q;
    end
  end

endmodule

// ===== rtl/skrf_ctrl.sv =====
// Controller: input and output handshakes and the step sequence of one update.
`timescale 1ns / 1ps
module skrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  output logic               out_valid,
  input  logic               out_stall,
  input  skrf_pkg::status_t  status,
  output skrf_pkg::cmd_t     cmd
);
  import skrf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_PRED    = 12'b000000000010,
    S_MUL_A   = 12'b000000000100,
    S_MUL_B   = 12'b000000001000,
    S_SUM     = 12'b000000010000,
    S_DLOAD_E = 12'b000000100000,
    S_DIV_E   = 12'b000001000000,
    S_FIN_E   = 12'b000010000000,
    S_DLOAD_V = 12'b000100000000,
    S_DIV_V   = 12'b001000000000,
    S_FIN_V   = 12'b010000000000,
    S_EMIT    = 12'b100000000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_GYRO) begin
            cmd.load_gyro = 1'b1;
          end else if (status.first) begin
            cmd.seed = 1'b1;
          end else begin
            state_next = S_PRED;
          end
        end
      end
      S_PRED: begin
        cmd.predict = 1'b1;
        state_next  = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        // both variances zero: keep the predicted estimate, clear the variance
        if (status.d_zero) begin
          cmd.zero_var = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_DLOAD_E;
        end
      end
      S_DLOAD_E: begin
        cmd.dload_e = 1'b1;
        cnt_next    = '0;
        state_next  = S_DIV_E;
      end
      S_DIV_E: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(EST_Q - 1)) begin
          state_next = S_FIN_E;
        end
      end
      S_FIN_E: begin
        cmd.fin_e  = 1'b1;
        state_next = S_DLOAD_V;
      end
      S_DLOAD_V: begin
        cmd.dload_v = 1'b1;
        cnt_next    = '0;
        state_next  = S_DIV_V;
      end
      S_DIV_V: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(VAR_Q - 1)) begin
          state_next = S_FIN_V;
        end
      end
      S_FIN_V: begin
        cmd.fin_v  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait only if the previous beat is still held
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/scalar_kalman_rate_fuser.sv =====
// Scalar Kalman yaw-rate fuser, top level.
// Gyro beat: taken, no result. First odometry beat: taken, no result.
// Later odometry beat: predict, multiply-accumulate, then the bit-serial divider
// (24 + 32 steps); the next beat is taken once the result is emitted. Both
// variances zero: no division. A held result does not block the next input beat.
// Reset (synchronous, active high) restores register defaults and filter state.
`timescale 1ns / 1ps
module scalar_kalman_rate_fuser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic signed [skrf_pkg::RATE_W-1:0]  rate_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [skrf_pkg::RATE_W-1:0]  rate_estimate,
  output logic [skrf_pkg::VAR_W-1:0]          estimate_variance,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [skrf_pkg::APB_AW-1:0]         paddr,
  input  logic [skrf_pkg::APB_DW-1:0]         pwdata,
  output logic [skrf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import skrf_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [VAR_W-1:0] process_var;
  logic [VAR_W-1:0] measure_var;

  skrf_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .process_var (process_var),
    .measure_var (measure_var)
  );

  skrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  skrf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .rate_sample       (rate_sample),
    .process_var       (process_var),
    .measure_var       (measure_var),
    .rate_estimate     (rate_estimate),
    .estimate_variance (estimate_variance)
  );

endmodule

// ===== tb/tb_scalar_kalman_rate_fuser.sv =====
// Self-checking testbench for the scalar Kalman yaw-rate fuser.
`timescale 1ns / 1ps
module tb_scalar_kalman_rate_fuser;
  import skrf_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 80;

  class kalman_rate_scoreboard;
    typedef struct packed {
      logic signed [RATE_W-1:0] est;
      logic [VAR_W-1:0]         vari;
    } fused_t;

    logic [VAR_W-1:0]         proc_var, meas_var, start_var;
    logic signed [RATE_W-1:0] est, gyro, prev;
    logic [VAR_W-1:0]         vari;
    bit                       awaiting_first;
    fused_t                   fused_due[$];
    int                       errors;

    function new();
      proc_var       = PROCESS_VAR_RST;
      meas_var       = MEASURE_VAR_RST;
      start_var      = START_VAR_RST;
      est            = '0;
      gyro           = '0;
      prev           = '0;
      vari           = START_VAR_RST;
      awaiting_first = 1'b1;
      errors         = 0;
    endfunction

    // start_var is only recorded; the filter variance starts from its default at reset
    function void write_reg(logic [1:0] idx, logic [VAR_W-1:0] v);
      case (idx)
        REG_PROCESS: proc_var = v;
        REG_MEASURE: meas_var = v;
        REG_START:   start_var = v;
        default: ;
      endcase
    endfunction

    function logic signed [RATE_W-1:0] clamp_rate(longint v);
      if (v > longint'(RATE_MAX)) return RATE_MAX;
      if (v < longint'(RATE_MIN)) return RATE_MIN;
      return v[RATE_W-1:0];
    endfunction

    function logic [VAR_W-1:0] clamp_var(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[VAR_W-1:0];
    endfunction

    // round to nearest, ties up
    function logic [63:0] div_nearest(logic [63:0] n, logic [63:0] d);
      logic [63:0] q, r;
      q = n / d;
      r = n % d;
      if (r >= d - r) q++;
      return q;
    endfunction

    function void note_sample(logic op, logic signed [RATE_W-1:0] r);
      longint      motion, num;
      logic [63:0] den, mag, q;
      fused_t      res;
      if (op == OP_GYRO) begin
        gyro = r;
        return;
      end
      if (awaiting_first) begin
        awaiting_first = 1'b0;
        prev = r;
        est  = r;
        return;
      end
      motion = longint'(gyro) - longint'(prev);
      prev   = gyro;
      vari   = clamp_var({32'd0, vari} + {32'd0, proc_var});
      est    = clamp_rate(longint'(est) + motion);
      den    = {32'd0, vari} + {32'd0, meas_var};
      if (den == 0) begin
        vari = '0;
      end else begin
        num = longint'({32'd0, meas_var}) * longint'(est)
            + longint'({32'd0, vari}) * longint'(gyro);
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = div_nearest(mag, den);
        if (q > 64'd16777216) q = 64'd16777216;
        est  = clamp_rate((num < 0) ? -longint'(q) : longint'(q));
        vari = clamp_var(div_nearest({32'd0, vari} * {32'd0, meas_var}, den));
      end
      res.est  = est;
      res.vari = vari;
      fused_due.push_back(res);
    endfunction

    function void check_fused(logic signed [RATE_W-1:0] e, logic [VAR_W-1:0] v);
      fused_t want;
      if (fused_due.size() == 0) begin
        $error("fused beat with nothing pending: rate_estimate %0d estimate_variance %0d",
               e, v);
        errors++;
        return;
      end
      want = fused_due.pop_front();
      if (e !== want.est) begin
        $error("rate_estimate: expected %0d, actual %0d", want.est, e);
        errors++;
      end
      if (v !== want.vari) begin
        $error("estimate_variance: expected %0d, actual %0d", want.vari, v);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid, in_stall, opcode;
  logic signed [RATE_W-1:0] rate_sample;
  logic                     out_valid, out_stall;
  logic signed [RATE_W-1:0] rate_estimate;
  logic [VAR_W-1:0]         estimate_variance;
  logic                     psel, penable, pwrite, pready;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata, prdata;

  kalman_rate_scoreboard sb;
  bit  burst   = 1'b0;   // no idling on either side while set
  bit  rx_hold = 1'b0;
  int  rx_wait = 0;

  scalar_kalman_rate_fuser u_dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .rate_sample,
    .out_valid, .out_stall, .rate_estimate, .estimate_variance,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  // result side: check accepted beats, then draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_fused(rate_estimate, estimate_variance);
      rx_wait = burst ? 0 : $urandom_range(0, 15);
    end else if (out_valid && rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= rx_hold || (rx_wait != 0);
  end

  task automatic send_beat(input logic op, input logic signed [RATE_W-1:0] r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    rate_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(op, r);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.fused_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic logic signed [RATE_W-1:0] rand_rate();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: return RATE_MAX;
      1: return RATE_MIN;
      2: return RATE_W'($signed($urandom_range(0, 2000)) - 1000);
      default: begin
        w = $urandom;
        return w[RATE_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [VAR_W-1:0] pick_var();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int  n;
    bit  paused;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_GYRO;
    rate_sample = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: gyro before seed, seed at the minimum, saturating motion
    send_beat(OP_GYRO, RATE_MAX);
    send_beat(OP_ODOM, RATE_MIN);
    send_beat(OP_ODOM, 24'sd123);
    send_beat(OP_GYRO, RATE_MIN);
    send_beat(OP_ODOM, '0);
    send_beat(OP_GYRO, '0);
    send_beat(OP_ODOM, RATE_MAX);
    send_beat(OP_GYRO, -24'sd1);
    send_beat(OP_ODOM, 24'sd1);
    send_beat(OP_ODOM, -24'sd1);
    send_beat(OP_GYRO, 24'sd1);
    send_beat(OP_GYRO, 24'sh555555);
    send_beat(OP_ODOM, 24'shAAAAAA);
    wait_drained(SETTLE_CYCLES);

    // saturated variances; unmapped register must not land anywhere
    apb_write(REG_PROCESS, 32'hFFFF_FFFF);
    apb_write(REG_MEASURE, 32'hFFFF_FFFF);
    apb_write(REG_START, 32'd0);
    apb_write(REG_UNMAPPED, 32'd7);
    send_beat(OP_GYRO, RATE_MAX);
    send_beat(OP_ODOM, '0);
    send_beat(OP_GYRO, RATE_MIN);
    send_beat(OP_ODOM, '0);
    send_beat(OP_ODOM, '0);
    wait_drained(SETTLE_CYCLES);

    // both variances driven to zero: second odometry beat hits the zero denominator
    apb_write(REG_PROCESS, 32'd0);
    apb_write(REG_MEASURE, 32'd0);
    send_beat(OP_GYRO, 24'sh123456);
    send_beat(OP_ODOM, '0);
    send_beat(OP_GYRO, -24'sd5);
    send_beat(OP_ODOM, '0);
    send_beat(OP_ODOM, '0);
    wait_drained(SETTLE_CYCLES);

    apb_write(REG_PROCESS, 32'd1);
    apb_write(REG_MEASURE, 32'd1);
    send_beat(OP_GYRO, 24'sd1000);
    send_beat(OP_ODOM, '0);
    wait_drained(SETTLE_CYCLES);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        apb_write(REG_PROCESS, PROCESS_VAR_RST);
        apb_write(REG_MEASURE, MEASURE_VAR_RST);
      end else begin
        apb_write(REG_PROCESS, pick_var());
        apb_write(REG_MEASURE, pick_var());
      end
      apb_write(REG_START, pick_var());
      n      = 0;
      paused = 1'b0;
      while (n < 120) begin
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        if ($urandom_range(0, 9) < 7) begin
          send_beat(OP_GYRO, rand_rate());
          send_beat(OP_ODOM, rand_rate());
          n += 2;
        end else begin
          send_beat($urandom_range(0, 1) ? OP_ODOM : OP_GYRO, rand_rate());
          n++;
        end
        if (n >= 60 && !paused) begin
          paused = 1'b1;
          if (ph == 0) begin
            // long result-side hold so the block backs up into its input
            fork
              begin
                rx_hold <= 1'b1;
                repeat (1000) @(posedge clk);
                rx_hold <= 1'b0;
              end
            join_none
          end else if (ph == 2) begin
            wait_drained(0);
          end
        end
      end
      wait_drained(SETTLE_CYCLES);
    end

    burst = 1'b0;
    wait_drained(SETTLE_CYCLES);
    if (sb.errors == 0 && sb.fused_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
